[rtl/core/lissajous_point_generator_assert.svh]
// assertion macros shared by the lissajous point generator rtl
`ifndef LISSAJOUS_POINT_GENERATOR_ASSERT_SVH
`define LISSAJOUS_POINT_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent and consequent in the same cycle
`define LPG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lissajous point generator: assertion failed");
// consequent in the cycle after the antecedent
`define LPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lissajous point generator: assertion failed");
`else
`define LPG_ASSERT_SAME(label, clk, rst, ante, cons)
`define LPG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/core/lpg_pkg.sv]
// types, register codes and sine table function for the lissajous point generator
`timescale 1ns / 1ps
`default_nettype none
package lpg_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PHASE_STEP_X = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PHASE_STEP_Y = 2'd3;

   // register widths and reset values
   localparam int CSR_DATA_W = 32;
   localparam int CFG_DIM_W  = 13;
   localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   // fixed point constants, q30 angles and amplitudes
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [31:0] SPAN_MID     = 32'h4000_0000;

   // folded sine sample: magnitude in q30 (at most one) and sign
   typedef struct packed {
      logic        neg;
      logic [30:0] mag;
   } sine_type;

   // q30 sine of u quarter-turn steps of 2^qbits, truncating horner series
   function automatic logic [30:0] sine_q30(input int unsigned u, input int unsigned qbits);
      logic [63:0] a;
      logic [63:0] a2;
      logic [63:0] t;
      logic [63:0] s;
      a  = (64'(u) * HALF_PI_Q30) >> qbits;
      a2 = (a * a) >> 30;
      t  = Q30_ONE - a2 / 64'd110;
      t  = Q30_ONE - ((a2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((a2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((a2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((a2 * t) >> 30) / 64'd6;
      s  = (a * t) >> 30;
      if (s > Q30_ONE) begin
         s = Q30_ONE;
      end
      return s[30:0];
   endfunction

endpackage
`default_nettype wire

[rtl/core/lpg_sine.sv]
// quadrant-folded sine lookup from a 32-bit phase
`timescale 1ns / 1ps
`default_nettype none
module lpg_sine #(
   parameter int TABLE_BITS = 10
) (
   input  wire logic [31:0]      phase,
   output lpg_pkg::sine_type     sine
);

   localparam int QBITS = TABLE_BITS - 2;
   localparam int QSIZE = 1 << QBITS;
   localparam logic [QBITS:0] QSIZE_U = (QBITS + 1)'(QSIZE);

   logic [30:0]           rom [QSIZE+1];
   logic [TABLE_BITS-1:0] idx;
   logic [1:0]            quad;
   logic [QBITS:0]        r_ext;
   logic [QBITS:0]        u;

   // first quarter of the sine wave, one entry past the end for the peak
   for (genvar g = 0; g <= QSIZE; g++) begin : g_rom
      assign rom[g] = lpg_pkg::sine_q30(g, QBITS);
   end

   // fold the table index onto the first quarter
   always_comb begin
      idx   = phase[31 -: TABLE_BITS];
      quad  = idx[TABLE_BITS-1 -: 2];
      r_ext = {1'b0, idx[QBITS-1:0]};
      u     = quad[0] ? (QSIZE_U - r_ext) : r_ext;
      sine.neg = quad[1];
      sine.mag = rom[u];
   end

endmodule
`default_nettype wire

[rtl/core/lissajous_point_generator.sv]
// lissajous point generator top level: phase accumulators and point pipeline
// throughput: one tick accepted per cycle while rsp_ready does not stall the output, set by the
//    four-stage registered pipeline (phase, sine lookup, scale, address)
// reset: synchronous; clears the phases, the point count (idle until a
//    frame start) and all valids, and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none
module lissajous_point_generator #(
   parameter int MAX_DIM_BITS    = 12,
   parameter int SINE_TABLE_BITS = 10,
   parameter int SAMPLES_PER_DIM = 15
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration writes
   input  wire logic                              csr_write_enable,
   input  wire logic [lpg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [lpg_pkg::CSR_DATA_W-1:0]    csr_write_data,
   // tick items
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_frame_start,
   // point items
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [11:0]                            rsp_point_x,
   output logic [11:0]                            rsp_point_y,
   output logic [23:0]                            rsp_pixel_address,
   output logic                                   rsp_last_point
);

`include "lissajous_point_generator_assert.svh"

   localparam int CFG_W  = lpg_pkg::CFG_DIM_W;
   localparam int DIM_W  = MAX_DIM_BITS + 1;
   localparam int CW     = (DIM_W > CFG_W) ? DIM_W : CFG_W;
   localparam int CNT_W  = DIM_W + 1 + $clog2(SAMPLES_PER_DIM + 1);
   localparam int PROD_W = MAX_DIM_BITS + 32;
   localparam int AW0    = DIM_W + MAX_DIM_BITS + 1;
   localparam int AW     = (AW0 > 24) ? AW0 : 24;
   localparam int PT_W   = (MAX_DIM_BITS > 12) ? MAX_DIM_BITS : 12;
   localparam logic [CW-1:0] DIM_TOP = CW'(1) << MAX_DIM_BITS;
   localparam logic [CW-1:0] DIM_MIN = CW'(2);

   // configuration registers
   logic [CFG_W-1:0] frame_width_ff;
   logic [CFG_W-1:0] frame_height_ff;
   logic [31:0]      phase_step_x_ff;
   logic [31:0]      phase_step_y_ff;

   // frame state
   logic [31:0]      phase_x_ff;
   logic [31:0]      phase_y_ff;
   logic [CNT_W-1:0] points_left_ff;

   // pipeline stages
   logic                      s1_valid_ff;
   logic [31:0]               s1_phase_x_ff;
   logic [31:0]               s1_phase_y_ff;
   logic                      s1_last_ff;
   logic                      s2_valid_ff;
   lpg_pkg::sine_type         s2_sin_x_ff;
   lpg_pkg::sine_type         s2_sin_y_ff;
   logic                      s2_last_ff;
   logic                      s3_valid_ff;
   logic [MAX_DIM_BITS-1:0]   s3_px_ff;
   logic [MAX_DIM_BITS-1:0]   s3_py_ff;
   logic                      s3_last_ff;
   logic                      rsp_valid_ff;
   logic [11:0]               rsp_x_ff;
   logic [11:0]               rsp_y_ff;
   logic [23:0]               rsp_addr_ff;
   logic                      rsp_last_ff;

   logic                      rdy1;
   logic                      rdy2;
   logic                      rdy3;
   logic                      rdy4;
   logic                      req_fire;
   logic [CW-1:0]             w_ext;
   logic [CW-1:0]             h_ext;
   logic [CW-1:0]             w_sat;
   logic [CW-1:0]             h_sat;
   logic [DIM_W-1:0]          w_dim;
   logic [DIM_W-1:0]          h_dim;
   logic [CNT_W-1:0]          frame_count;
   logic [CNT_W-1:0]          count_eff;
   logic [31:0]               phase_x_eff;
   logic [31:0]               phase_y_eff;
   logic                      emit;
   lpg_pkg::sine_type         sin_x;
   lpg_pkg::sine_type         sin_y;
   logic [31:0]               span_x;
   logic [31:0]               span_y;
   logic [DIM_W-1:0]          wm1_full;
   logic [DIM_W-1:0]          hm1_full;
   logic [PROD_W-1:0]         prod_x;
   logic [PROD_W-1:0]         prod_y;
   logic [AW-1:0]             addr_full;
   logic [PT_W-1:0]           px_ext;
   logic [PT_W-1:0]           py_ext;

   // configuration write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= lpg_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= lpg_pkg::FRAME_HEIGHT_RESET;
         phase_step_x_ff <= '0;
         phase_step_y_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lpg_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= csr_write_data[CFG_W-1:0];
            lpg_pkg::REG_FRAME_HEIGHT: frame_height_ff <= csr_write_data[CFG_W-1:0];
            lpg_pkg::REG_PHASE_STEP_X: phase_step_x_ff <= csr_write_data[31:0];
            lpg_pkg::REG_PHASE_STEP_Y: phase_step_y_ff <= csr_write_data[31:0];
            default: ;
         endcase
      end
   end

   // saturate the dimensions to the supported range
   always_comb begin
      w_ext = CW'(frame_width_ff);
      h_ext = CW'(frame_height_ff);
      w_sat = (w_ext < DIM_MIN) ? DIM_MIN : ((w_ext > DIM_TOP) ? DIM_TOP : w_ext);
      h_sat = (h_ext < DIM_MIN) ? DIM_MIN : ((h_ext > DIM_TOP) ? DIM_TOP : h_ext);
      w_dim = w_sat[DIM_W-1:0];
      h_dim = h_sat[DIM_W-1:0];
      frame_count = CNT_W'(SAMPLES_PER_DIM) * (CNT_W'(w_dim) + CNT_W'(h_dim));
   end

   // stage handshakes, each stage fills when the next one moves or is empty
   assign rdy4      = !rsp_valid_ff || rsp_ready;
   assign rdy3      = !s3_valid_ff || rdy4;
   assign rdy2      = !s2_valid_ff || rdy3;
   assign rdy1      = !s1_valid_ff || rdy2;
   assign req_ready = rdy1;
   assign req_fire  = req_valid && rdy1;

   // frame start overrides the running phases and count
   always_comb begin
      count_eff   = req_frame_start ? frame_count : points_left_ff;
      phase_x_eff = req_frame_start ? '0 : phase_x_ff;
      phase_y_eff = req_frame_start ? '0 : phase_y_ff;
      emit        = (count_eff != '0);
   end

   // phase accumulators and point count
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_x_ff     <= '0;
         phase_y_ff     <= '0;
         points_left_ff <= '0;
      end else if (req_fire && emit) begin
         phase_x_ff     <= phase_x_eff + phase_step_x_ff;
         phase_y_ff     <= phase_y_eff + phase_step_y_ff;
         points_left_ff <= count_eff - CNT_W'(1);
      end
   end

   // sine lookups for both axes, cosine as a quarter turn ahead
   lpg_sine #(.TABLE_BITS(SINE_TABLE_BITS)) u_sine_x (
      .phase (s1_phase_x_ff),
      .sine  (sin_x)
   );

   lpg_sine #(.TABLE_BITS(SINE_TABLE_BITS)) u_sine_y (
      .phase (s1_phase_y_ff),
      .sine  (sin_y)
   );

   // scale (1 + sine) / 2 onto the image span
   always_comb begin
      span_x   = s2_sin_x_ff.neg ? (lpg_pkg::SPAN_MID - {1'b0, s2_sin_x_ff.mag})
                                 : (lpg_pkg::SPAN_MID + {1'b0, s2_sin_x_ff.mag});
      span_y   = s2_sin_y_ff.neg ? (lpg_pkg::SPAN_MID - {1'b0, s2_sin_y_ff.mag})
                                 : (lpg_pkg::SPAN_MID + {1'b0, s2_sin_y_ff.mag});
      wm1_full = w_dim - DIM_W'(1);
      hm1_full = h_dim - DIM_W'(1);
      prod_x   = PROD_W'(wm1_full[MAX_DIM_BITS-1:0]) * PROD_W'(span_x);
      prod_y   = PROD_W'(hm1_full[MAX_DIM_BITS-1:0]) * PROD_W'(span_y);
   end

   // linear address and output widths
   always_comb begin
      addr_full = AW'(w_dim) * AW'(s3_py_ff) + AW'(s3_px_ff);
      px_ext    = PT_W'(s3_px_ff);
      py_ext    = PT_W'(s3_py_ff);
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            s1_valid_ff <= req_fire && emit;
         end
         if (rdy2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (rdy3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (rdy4) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_phase_x_ff <= phase_x_eff;
         s1_phase_y_ff <= phase_y_eff + lpg_pkg::QUARTER_TURN;
         s1_last_ff    <= (count_eff == CNT_W'(1));
      end
      if (rdy2) begin
         s2_sin_x_ff <= sin_x;
         s2_sin_y_ff <= sin_y;
         s2_last_ff  <= s1_last_ff;
      end
      if (rdy3) begin
         s3_px_ff   <= prod_x[MAX_DIM_BITS+30:31];
         s3_py_ff   <= prod_y[MAX_DIM_BITS+30:31];
         s3_last_ff <= s2_last_ff;
      end
      if (rdy4) begin
         rsp_x_ff    <= px_ext[11:0];
         rsp_y_ff    <= py_ext[11:0];
         rsp_addr_ff <= addr_full[23:0];
         rsp_last_ff <= s3_last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_point_x       = rsp_x_ff;
   assign rsp_point_y       = rsp_y_ff;
   assign rsp_pixel_address = rsp_addr_ff;
   assign rsp_last_point    = rsp_last_ff;

   // checks on frame sequencing and stage flow
   `LPG_ASSERT_NEXT(a_idle_tick_no_point, clock, reset,
      req_fire && !req_frame_start && points_left_ff == '0, !s1_valid_ff)
   `LPG_ASSERT_NEXT(a_start_at_phase_zero, clock, reset,
      req_fire && req_frame_start, s1_valid_ff && s1_phase_x_ff == '0)
   `LPG_ASSERT_NEXT(a_last_point_ends_frame, clock, reset,
      req_fire && !req_frame_start && points_left_ff == CNT_W'(1),
      points_left_ff == '0 && s1_last_ff)
   `LPG_ASSERT_NEXT(a_stalled_stage_kept, clock, reset,
      s3_valid_ff && !rdy4, s3_valid_ff)
   `LPG_ASSERT_SAME(a_ready_when_empty, clock, reset,
      !s1_valid_ff, req_ready)

endmodule
`default_nettype wire
